/* rtl/core/mpo_pkg.sv */
// Shared types and constants of the multiwave phase oscillator.
`default_nettype none

package mpo_pkg;

  // Waveform codes
  localparam logic [2:0] WAVE_SQUARE      = 3'd0;
  localparam logic [2:0] WAVE_SAW         = 3'd1;
  localparam logic [2:0] WAVE_TRIANGLE    = 3'd2;
  localparam logic [2:0] WAVE_LFSR15_TAP1 = 3'd3;
  localparam logic [2:0] WAVE_LFSR15_TAP6 = 3'd4;
  localparam logic [2:0] WAVE_LFSR15_XOR  = 3'd5;
  localparam logic [2:0] WAVE_LFSR7_XOR   = 3'd6;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_WAVEFORM   = 3'd0;
  localparam logic [2:0] REG_DUTY_CYCLE = 3'd1;
  localparam logic [2:0] REG_QUANTIZE   = 3'd2;
  localparam logic [2:0] REG_SKEW       = 3'd3;
  localparam logic [2:0] REG_LFSR_SEED  = 3'd4;

  // Register reset values
  localparam logic [24:0] DUTY_RESET = 25'd8388608;
  localparam logic [14:0] SEED_RESET = 15'd1;

  // Noise register feedback constants
  localparam logic [14:0] LFSR_TOP_BIT  = 15'h4000;
  localparam logic [14:0] LFSR15_TAPS   = 15'h6000;
  localparam logic [14:0] LFSR7_TAPS    = 15'h0060;
  localparam logic [14:0] LFSR7_MASK    = 15'h007F;

  // Output levels
  localparam logic [14:0] FULL_SCALE = 15'd32767;
  localparam logic [15:0] SAMPLE_POS = 16'h7FFF;
  localparam logic [15:0] SAMPLE_NEG = 16'h8001;
  localparam logic [15:0] SAMPLE_ZERO = 16'h0000;

  // Iterative divider sizes
  localparam int DIV_NUM_W = 32;
  localparam int DIV_DEN_W = 15;

  // Configuration as seen by the core
  typedef struct packed {
    logic [2:0]  waveform;
    logic [24:0] duty_cycle;
    logic [6:0]  quantize_steps;
    logic        skew_enable;
    logic [14:0] lfsr_seed;
    logic        seed_wr;
  } cfg_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_POW2,
    ST_MUL_K,
    ST_K,
    ST_MUL_DD,
    ST_MUL_T,
    ST_NUM,
    ST_SCALE,
    ST_DIV,
    ST_OUT
  } state_e;

  // Shared multiplier operand select
  typedef enum logic [1:0] {
    MUL_LVL_Q,
    MUL_D_D,
    MUL_X_DX
  } mul_sel_e;

endpackage

`default_nettype wire

/* rtl/core/mpo_cfg.sv */
// APB configuration registers of the multiwave phase oscillator.
`default_nettype none

module mpo_cfg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready,
  output mpo_pkg::cfg_t      cfg_o
);
  import mpo_pkg::*;

  logic [2:0]  waveform_q;
  logic [24:0] duty_q;
  logic [6:0]  quant_q;
  logic        skew_q;
  logic [14:0] seed_q;
  logic        seed_wr_q;
  logic [2:0]  idx;
  logic        wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes; seed write also pulses a reload of the noise register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waveform_q <= WAVE_SQUARE;
      duty_q     <= DUTY_RESET;
      quant_q    <= 7'd0;
      skew_q     <= 1'b0;
      seed_q     <= SEED_RESET;
      seed_wr_q  <= 1'b0;
    end else begin
      seed_wr_q <= 1'b0;
      if (wr_en) begin
        case (idx)
          REG_WAVEFORM:   waveform_q <= pwdata[2:0];
          REG_DUTY_CYCLE: duty_q     <= pwdata[24:0];
          REG_QUANTIZE:   quant_q    <= pwdata[6:0];
          REG_SKEW:       skew_q     <= pwdata[0];
          REG_LFSR_SEED: begin
            seed_q    <= pwdata[14:0];
            seed_wr_q <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_WAVEFORM:   prdata = {29'd0, waveform_q};
      REG_DUTY_CYCLE: prdata = {7'd0, duty_q};
      REG_QUANTIZE:   prdata = {25'd0, quant_q};
      REG_SKEW:       prdata = {31'd0, skew_q};
      REG_LFSR_SEED:  prdata = {17'd0, seed_q};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg_o = '{
    waveform:       waveform_q,
    duty_cycle:     duty_q,
    quantize_steps: quant_q,
    skew_enable:    skew_q,
    lfsr_seed:      seed_q,
    seed_wr:        seed_wr_q
  };

endmodule

`default_nettype wire

/* rtl/core/mpo_div.sv */
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module mpo_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [mpo_pkg::DIV_NUM_W-1:0] num_i,
  input  wire logic [mpo_pkg::DIV_DEN_W-1:0] den_i,
  output logic                               done_o,
  output logic      [mpo_pkg::DIV_NUM_W-1:0] quot_o
);
  import mpo_pkg::*;

  localparam int CntW = $clog2(DIV_NUM_W + 1);

  logic [CntW-1:0]      cnt_q;
  logic                 done_q;
  logic [DIV_NUM_W-1:0] quot_q;
  logic [DIV_DEN_W-1:0] rem_q;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W+1:0] diff;
  logic                 ge;

  // One shift-subtract step
  assign rem_sh = {rem_q, quot_q[DIV_NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - (DIV_DEN_W + 2)'(den_q);
  assign ge     = !diff[DIV_DEN_W+1];

  // Step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CntW'(DIV_NUM_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
    end else if (cnt_q != '0) begin
      quot_q <= {quot_q[DIV_NUM_W-2:0], ge};
      rem_q  <= ge ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

/* rtl/core/multiwave_phase_oscillator_core.sv */
// Top level of the multiwave phase oscillator: sequencer, datapath and noise register.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+---------------------------
//   in      | input     | in_valid_i / in_stall_o   | phase_step_i[23:0], hold_i
//   out     | output    | out_valid_o / out_stall_i | sample_o[15:0] signed
//   cfg     | input     | APB psel/penable/pready   | paddr[4:0], pwdata, prdata
//
// An item is taken only while the sequencer is idle. Held items, square, noise
// and the unused code go from dispatch to output; saw and plain triangle pass
// the power-of-two state; the quantized triangle waits on the 32-step divider.
// The output register holds a result under out_stall_i while the next item
// is taken; the sequencer waits in its last state until that register frees.
// Reset clears phase, wrap history and held sample and loads the seed.
`default_nettype none

module multiwave_phase_oscillator_core #(
  parameter int PHASE_BITS = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [23:0] phase_step_i,
  input  wire logic        hold_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [15:0] sample_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import mpo_pkg::*;

  localparam int StepW = (PHASE_BITS > 24) ? PHASE_BITS : 24;
  localparam int CmpW  = (PHASE_BITS + 1 > 25) ? PHASE_BITS + 1 : 25;
  localparam int LvlW  = PHASE_BITS + 1;
  localparam int ProdW = PHASE_BITS + 9;
  localparam int ScW   = PHASE_BITS + 17;

  cfg_t cfg;

  state_e   state_q, state_d;
  mul_sel_e mul_sel;
  logic     div_start;
  logic     out_load;

  logic [PHASE_BITS-1:0] phase_acc_q;
  logic [PHASE_BITS-1:0] prev_phase_q;
  logic [PHASE_BITS-1:0] ph_q;
  logic [14:0]           noise_q;
  logic [15:0]           held_q;
  logic                  hold_q;
  logic [15:0]           res_q;
  logic                  out_valid_q;
  logic [15:0]           sample_q;
  logic [ProdW-1:0]      prod_q;
  logic [6:0]            k_q;
  logic [13:0]           dd_q;
  logic signed [16:0]    num_q;
  logic [13:0]           den_q;

  logic                  accept;
  logic                  out_free;
  logic [StepW-1:0]      step_w;
  logic                  wrapped;
  logic                  is_noise;
  logic [LvlW-1:0]       lvl;
  logic [6:0]            d;
  logic                  q_big;
  logic [6:0]            k;
  logic [6:0]            x;
  logic [7:0]            dx;
  logic [LvlW-1:0]       mul_a;
  logic [7:0]            mul_b;
  logic [ProdW-1:0]      mul_p;
  logic [LvlW-1:0]       v;
  logic [PHASE_BITS+1:0] v2;
  logic [PHASE_BITS+1:0] one2;
  logic                  p2_neg;
  logic [PHASE_BITS+1:0] p2_mag;
  logic [ScW-1:0]        p2_sc;
  logic [16:0]           num_abs;
  logic [33:0]           numer;
  logic                  div_done;
  logic [DIV_NUM_W-1:0]  quot;

  // Next noise register value for the selected style
  function automatic logic [14:0] lfsr_next(input logic [14:0] s, input logic [2:0] wave);
    logic [14:0] t;
    begin
      case (wave)
        WAVE_LFSR15_TAP1: t = (s >> 1) | ((s[0] ^ s[1]) ? LFSR_TOP_BIT : 15'd0);
        WAVE_LFSR15_TAP6: t = (s >> 1) | ((s[0] ^ s[6]) ? LFSR_TOP_BIT : 15'd0);
        WAVE_LFSR15_XOR:  t = (s >> 1) ^ (s[0] ? LFSR15_TAPS : 15'd0);
        default:          t = ((s & LFSR7_MASK) >> 1) ^ (s[0] ? LFSR7_TAPS : 15'd0);
      endcase
      return t;
    end
  endfunction

  // Saturate a magnitude to full scale and apply the sign
  function automatic logic [15:0] mk_sample(input logic neg, input logic [31:0] r);
    logic [15:0] m;
    begin
      m = (r > 32'(FULL_SCALE)) ? {1'b0, FULL_SCALE} : {1'b0, r[14:0]};
      return neg ? 16'd0 - m : m;
    end
  endfunction

  mpo_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake
  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // Phase and wrap
  assign step_w   = StepW'(phase_step_i);
  assign wrapped  = prev_phase_q > phase_acc_q;
  assign is_noise = (cfg.waveform == WAVE_LFSR15_TAP1) || (cfg.waveform == WAVE_LFSR15_TAP6) ||
                    (cfg.waveform == WAVE_LFSR15_XOR) || (cfg.waveform == WAVE_LFSR7_XOR);

  // Triangle level, steps and skew operands
  assign lvl   = ph_q[PHASE_BITS-1] ? LvlW'(0) - {ph_q, 1'b0} : {ph_q, 1'b0};
  assign d     = cfg.quantize_steps - 7'd1;
  assign q_big = cfg.quantize_steps > 7'd1;
  assign k     = prod_q[PHASE_BITS+6:PHASE_BITS];
  assign x     = ph_q[PHASE_BITS-1] ? k_q : d - k_q;
  assign dx    = {1'b0, d} + {1'b0, x};

  // Shared multiplier
  always_comb begin
    case (mul_sel)
      MUL_LVL_Q: begin
        mul_a = lvl;
        mul_b = {1'b0, cfg.quantize_steps};
      end
      MUL_D_D: begin
        mul_a = LvlW'(d);
        mul_b = {1'b0, d};
      end
      MUL_X_DX: begin
        mul_a = LvlW'(x);
        mul_b = dx;
      end
      default: begin
        mul_a = lvl;
        mul_b = {1'b0, cfg.quantize_steps};
      end
    endcase
  end
  assign mul_p = ProdW'(mul_a) * ProdW'(mul_b);

  // Power-of-two denominator path: saw and plain triangle
  assign v      = (cfg.waveform == WAVE_SAW) ? {1'b0, ph_q} : lvl;
  assign v2     = {v, 1'b0};
  assign one2   = (PHASE_BITS + 2)'(1) << PHASE_BITS;
  assign p2_neg = v2 < one2;
  assign p2_mag = p2_neg ? one2 - v2 : v2 - one2;
  assign p2_sc  = (ScW'(p2_mag) << 15) - ScW'(p2_mag) + (ScW'(1) << (PHASE_BITS - 1));

  // Divider operands: round(32767 * num / den) = (2*|num|*32767 + den) / (2*den)
  assign num_abs = num_q[16] ? 17'd0 - num_q : num_q;
  assign numer   = (34'(num_abs[15:0]) << 16) - (34'(num_abs[15:0]) << 1) + 34'(den_q);

  mpo_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (numer[DIV_NUM_W-1:0]),
    .den_i   ({den_q, 1'b0}),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (accept) state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        if (hold_q) begin
          state_d = ST_OUT;
        end else begin
          case (cfg.waveform)
            WAVE_SAW:      state_d = ST_POW2;
            WAVE_TRIANGLE: state_d = q_big ? ST_MUL_K : ST_POW2;
            default:       state_d = ST_OUT;
          endcase
        end
      end
      ST_POW2:   state_d = ST_OUT;
      ST_MUL_K:  state_d = ST_K;
      ST_K:      state_d = cfg.skew_enable ? ST_MUL_DD : ST_SCALE;
      ST_MUL_DD: state_d = ST_MUL_T;
      ST_MUL_T:  state_d = ST_NUM;
      ST_NUM:    state_d = ST_SCALE;
      ST_SCALE:  state_d = ST_DIV;
      ST_DIV:    if (div_done) state_d = ST_OUT;
      ST_OUT:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer: control outputs
  always_comb begin
    mul_sel    = MUL_LVL_Q;
    div_start  = 1'b0;
    out_load   = 1'b0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE:   in_stall_o = 1'b0;
      ST_MUL_DD: mul_sel = MUL_D_D;
      ST_MUL_T:  mul_sel = MUL_X_DX;
      ST_SCALE:  div_start = 1'b1;
      ST_OUT:    out_load = out_free;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Oscillator state: phase, wrap history, noise register, held sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_acc_q  <= '0;
      prev_phase_q <= '0;
      noise_q      <= SEED_RESET;
      held_q       <= SAMPLE_ZERO;
      hold_q       <= 1'b0;
    end else begin
      if (accept) begin
        hold_q <= hold_i;
        if (!hold_i) begin
          prev_phase_q <= phase_acc_q;
          phase_acc_q  <= phase_acc_q + step_w[PHASE_BITS-1:0];
        end
      end
      if (cfg.seed_wr) begin
        noise_q <= cfg.lfsr_seed;
      end else if (accept && !hold_i && is_noise && wrapped) begin
        noise_q <= lfsr_next(noise_q, cfg.waveform);
      end
      if (out_load) begin
        held_q <= res_q;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (accept) begin
      ph_q <= phase_acc_q;
    end
    case (state_q)
      ST_DISPATCH: begin
        if (hold_q) begin
          res_q <= held_q;
        end else begin
          case (cfg.waveform)
            WAVE_SQUARE:
              res_q <= (CmpW'(ph_q) < CmpW'(cfg.duty_cycle)) ? SAMPLE_POS : SAMPLE_NEG;
            WAVE_LFSR15_TAP1, WAVE_LFSR15_TAP6, WAVE_LFSR15_XOR, WAVE_LFSR7_XOR:
              res_q <= noise_q[0] ? SAMPLE_POS : SAMPLE_NEG;
            default:
              res_q <= SAMPLE_ZERO;
          endcase
        end
      end
      ST_POW2: res_q <= mk_sample(p2_neg, 32'(p2_sc[ScW-1:PHASE_BITS]));
      ST_K: begin
        k_q   <= k;
        num_q <= $signed(17'({k, 1'b0}) - 17'(d));
        den_q <= 14'(d);
      end
      ST_MUL_T: dd_q <= prod_q[13:0];
      ST_NUM: begin
        // first half: d^2 - j(d+j); second half: k(d+k) - d^2
        num_q <= ph_q[PHASE_BITS-1] ? $signed(17'(prod_q[14:0]) - 17'(dd_q))
                                    : $signed(17'(dd_q) - 17'(prod_q[14:0]));
        den_q <= dd_q;
      end
      ST_DIV: if (div_done) res_q <= mk_sample(num_q[16], quot);
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sample_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

endmodule

`default_nettype wire
